// ===== hdl/nfgcp_pkg.sv =====
package nfgcp_pkg;

   localparam int GRID_SIDE  = 64;
   localparam int NODE_SLOTS = 256;

   localparam int CW    = $clog2(GRID_SIDE);   // coordinate width
   localparam int IDW   = $clog2(NODE_SLOTS);  // node id width
   localparam int RW    = CW + 2;              // ring radius width, up to 2*(GRID_SIDE-1)+2
   localparam int POS_W = 12;

   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_REINSERT = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PARENT = 2'd1;
   localparam logic [1:0] ST_NO_CELL  = 2'd2;
   localparam logic [1:0] ST_DUP_ID   = 2'd3;

   localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_PROBE,
      S_CHECK,
      S_MARK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } cell_type;

   // clamp a signed coordinate into 0..lim
   function automatic logic [CW-1:0] clamp_pos(input logic [POS_W-1:0] v,
                                              input logic [CW-1:0] lim);
      logic [CW-1:0] r;
      if (v[POS_W-1]) begin
         r = '0;
      end else if (v[POS_W-2:0] > {{(POS_W-1-CW){1'b0}}, lim}) begin
         r = lim;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/nearest_free_grid_cell_placer_unit.sv =====
// From the accepting edge to rsp_tvalid, a clear, duplicate or missing-parent item passes through
// DISPATCH and DONE, a load through DISPATCH, MARK and DONE. A reinsert walks the rings in PROBE,
// which skips ring columns outside the grid and reads the occupancy row of a column inside it, and
// CHECK, which checks both cells of that column, then MARK for a found cell, and DONE. One item at
// a time; a result held by rsp_tready holds the block. The occupancy row port sets the search rate.
// Reset (synchronous, active high): grid limits 63, all cells free, all node slots empty,
// no result pending. Row and slot valid flops make the clear immediate, no clearing pass.
module nearest_free_grid_cell_placer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], node_id[9:2], parent_id[17:10], pos_x[29:18], pos_y[41:30], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], out_x[7:2], out_y[13:8], zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import nfgcp_pkg::*;

   state_type state_ff, state_in;

   logic [CW-1:0] grid_w_ff, grid_h_ff;

   logic [1:0]     act_ff, act_in;
   logic [IDW-1:0] nid_ff, nid_in;
   logic [IDW-1:0] pid_ff, pid_in;
   logic [CW-1:0]  x_ff, x_in;      // target cell
   logic [CW-1:0]  y_ff, y_in;
   logic [CW-1:0]  px_ff, px_in;    // parent cell
   logic [CW-1:0]  py_ff, py_in;
   logic [RW-1:0]  r_ff, r_in;
   logic signed [RW:0] dx_ff, dx_in;

   logic [1:0]    res_status_ff, res_status_in;
   logic [CW-1:0] res_x_ff, res_x_in;
   logic [CW-1:0] res_y_ff, res_y_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_x_ff, rsp_x_in;
   logic [CW-1:0] rsp_y_ff, rsp_y_in;

   // node position table
   logic [2*CW-1:0]       tab_mem [NODE_SLOTS];
   logic [NODE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic                  tab_re, tab_we;
   logic [IDW-1:0]        tab_raddr, tab_waddr;
   logic [2*CW-1:0]       tab_wdata;
   cell_type              tab_rdata_ff;

   // occupancy map, one row per x, bit per y
   logic [GRID_SIDE-1:0]  occ_mem [GRID_SIDE];
   logic [GRID_SIDE-1:0]  row_valid_ff, row_valid_in;
   logic                  occ_re, occ_we;
   logic [CW-1:0]         occ_raddr, occ_waddr;
   logic [GRID_SIDE-1:0]  occ_wdata;
   logic [GRID_SIDE-1:0]  occ_rdata_ff;
   logic                  occ_rvalid_ff;
   logic [GRID_SIDE-1:0]  row_bits;

   // request fields
   logic [1:0]       f_action;
   logic [IDW-1:0]   f_nid, f_pid;
   logic [POS_W-1:0] f_px, f_py;
   logic             req_xfer;

   // ring walk arithmetic
   logic [RW:0]          dx_mag;
   logic [RW-1:0]        rem;
   logic signed [RW+1:0] cx, cy_lo;
   logic [RW:0]          cy_hi;
   logic [RW-1:0]        rmax;
   logic                 cx_in, lo_in, hi_in, lo_free, hi_free;
   logic [RW-1:0]        r_next;

   assign f_action = req_tdata[1:0];
   assign f_nid    = req_tdata[9:2];
   assign f_pid    = req_tdata[17:10];
   assign f_px     = req_tdata[29:18];
   assign f_py     = req_tdata[41:30];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_y_ff, rsp_x_ff, rsp_status_ff};

   assign row_bits = occ_rvalid_ff ? occ_rdata_ff : '0;

   assign dx_mag = dx_ff[RW] ? -dx_ff : dx_ff;
   assign rem    = r_ff - dx_mag[RW-1:0];
   assign cx     = $signed({{(RW+2-CW){1'b0}}, px_ff}) + $signed({dx_ff[RW], dx_ff});
   assign cy_lo  = $signed({2'b00, {(RW-CW){1'b0}}, py_ff}) - $signed({2'b00, rem});
   assign cy_hi  = {{(RW+1-CW){1'b0}}, py_ff} + {1'b0, rem};
   assign rmax   = {{(RW-CW){1'b0}}, grid_w_ff} + {{(RW-CW){1'b0}}, grid_h_ff} + RW'(2);
   assign r_next = r_ff + RW'(1);

   assign cx_in = !cx[RW+1] && (cx[RW:0] <= {{(RW+1-CW){1'b0}}, grid_w_ff});
   assign lo_in = !cy_lo[RW+1] && (cy_lo[RW:0] <= {{(RW+1-CW){1'b0}}, grid_h_ff});
   assign hi_in = (cy_hi <= {{(RW+1-CW){1'b0}}, grid_h_ff});
   assign lo_free = lo_in && !row_bits[cy_lo[CW-1:0]];
   assign hi_free = (rem != '0) && hi_in && !row_bits[cy_hi[CW-1:0]];

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      nid_in        = nid_ff;
      pid_in        = pid_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      r_in          = r_ff;
      dx_in         = dx_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      slot_valid_in = slot_valid_ff;
      row_valid_in  = row_valid_ff;
      tab_re        = 1'b0;
      tab_raddr     = f_nid;
      tab_we        = 1'b0;
      tab_waddr     = nid_ff;
      tab_wdata     = {x_ff, y_ff};
      occ_re        = 1'b0;
      occ_raddr     = x_ff;
      occ_we        = 1'b0;
      occ_waddr     = x_ff;
      occ_wdata     = row_bits | (GRID_SIDE'(1) << y_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in    = f_action;
               nid_in    = f_nid;
               pid_in    = f_pid;
               x_in      = clamp_pos(f_px, grid_w_ff);
               y_in      = clamp_pos(f_py, grid_h_ff);
               // duplicate needs the node's entry, a reinsert the parent's
               tab_re    = 1'b1;
               tab_raddr = slot_valid_ff[f_nid] ? f_nid : f_pid;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in = ST_OK;
            res_x_in      = '0;
            res_y_in      = '0;
            state_in      = S_DONE;
            case (act_ff)
               ACT_CLEAR: begin
                  slot_valid_in = '0;
                  row_valid_in  = '0;
               end
               ACT_LOAD, ACT_REINSERT: begin
                  if (slot_valid_ff[nid_ff]) begin
                     res_status_in = ST_DUP_ID;
                     res_x_in      = tab_rdata_ff.x;
                     res_y_in      = tab_rdata_ff.y;
                  end else if (act_ff == ACT_LOAD) begin
                     tab_we                = 1'b1;
                     slot_valid_in[nid_ff] = 1'b1;
                     occ_re                = 1'b1;
                     state_in              = S_MARK;
                  end else if (!slot_valid_ff[pid_ff]) begin
                     res_status_in = ST_NO_PARENT;
                  end else begin
                     // limits may have shrunk since the parent was placed
                     px_in    = (tab_rdata_ff.x > grid_w_ff) ? grid_w_ff : tab_rdata_ff.x;
                     py_in    = (tab_rdata_ff.y > grid_h_ff) ? grid_h_ff : tab_rdata_ff.y;
                     r_in     = RW'(1);
                     dx_in    = -$signed((RW+1)'(1));
                     state_in = S_PROBE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_PROBE: begin
            if (cx_in) begin
               occ_re    = 1'b1;
               occ_raddr = cx[CW-1:0];
               state_in  = S_CHECK;
            end else if (dx_ff == $signed({1'b0, r_ff})) begin
               if (r_ff == rmax) begin
                  res_status_in = ST_NO_CELL;
                  res_x_in      = '0;
                  res_y_in      = '0;
                  state_in      = S_DONE;
               end else begin
                  r_in  = r_next;
                  dx_in = -$signed({1'b0, r_next});
               end
            end else begin
               dx_in = dx_ff + (RW+1)'(1);
            end
         end
         S_CHECK: begin
            if (lo_free || hi_free) begin
               x_in                  = cx[CW-1:0];
               y_in                  = lo_free ? cy_lo[CW-1:0] : cy_hi[CW-1:0];
               tab_we                = 1'b1;
               tab_wdata             = {cx[CW-1:0], y_in};
               slot_valid_in[nid_ff] = 1'b1;
               state_in              = S_MARK;
            end else if (dx_ff == $signed({1'b0, r_ff})) begin
               if (r_ff == rmax) begin
                  res_status_in = ST_NO_CELL;
                  res_x_in      = '0;
                  res_y_in      = '0;
                  state_in      = S_DONE;
               end else begin
                  r_in     = r_next;
                  dx_in    = -$signed({1'b0, r_next});
                  state_in = S_PROBE;
               end
            end else begin
               dx_in    = dx_ff + (RW+1)'(1);
               state_in = S_PROBE;
            end
         end
         S_MARK: begin
            // row of x_ff was read in DISPATCH for a load, in PROBE for a reinsert
            occ_we            = 1'b1;
            row_valid_in[x_ff] = 1'b1;
            res_status_in     = ST_OK;
            res_x_in          = x_ff;
            res_y_in          = y_ff;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         grid_w_ff     <= '1;
         grid_h_ff     <= '1;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         row_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         row_valid_ff  <= row_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_GRID_WIDTH:  grid_w_ff <= csr_wdata[CW-1:0];
               REG_GRID_HEIGHT: grid_h_ff <= csr_wdata[CW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      nid_ff        <= nid_in;
      pid_ff        <= pid_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      r_ff          <= r_in;
      dx_ff         <= dx_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      if (tab_re) begin
         tab_rdata_ff <= tab_mem[tab_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      if (occ_re) begin
         occ_rdata_ff  <= occ_mem[occ_raddr];
         occ_rvalid_ff <= row_valid_ff[occ_raddr];
      end
   end

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_PROBE))
      else $error("row check without a preceding row read");

   a_ring_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ((r_ff != '0) && (r_ff <= rmax) &&
                                 (dx_mag <= {1'b0, r_ff})))
      else $error("ring walk out of range");

   a_mark_sets_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> slot_valid_ff[nid_ff])
      else $error("cell marked for a node with no recorded slot");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result dropped on the way to the output register");

endmodule
